// File: hdl/lru_tag_cache_lookup_assert.svh
// Assertion macros shared by the cache lookup modules.
`ifndef LRU_TAG_CACHE_LOOKUP_ASSERT_SVH
`define LRU_TAG_CACHE_LOOKUP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define LTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lookup assertion failed");

// Next-cycle implication, off while reset is asserted.
`define LTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lookup assertion failed");

`endif

// File: hdl/ltc_pkg.sv
package ltc_pkg;

	localparam int unsigned ID_W        = 32;
	localparam int unsigned CNT_W       = 32;
	localparam int unsigned WAY_W       = 6;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_CACHE_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STORED_COUNT = 2'd1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic evaluate;
		logic commit;
	} ltc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_blocked;
	} ltc_status_t;

endpackage

// File: hdl/ltc_ctrl.sv
`include "lru_tag_cache_lookup_assert.svh"

module ltc_ctrl import ltc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ltc_status_t status,
	output ltc_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next   = state_q;
		cmd.capture  = 1'b0;
		cmd.evaluate = 1'b0;
		cmd.commit   = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_next = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.evaluate = 1'b1;
				state_next   = ST_UPD;
			end
			ST_UPD: begin
				// hold the update while the previous result is still waiting
				if (!status.out_blocked) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	`LTC_ASSERT_NXT(a_accept_then_eval, clk, arst_n, in_valid && in_ready, cmd.evaluate)

endmodule

// File: hdl/ltc_datapath.sv
`include "lru_tag_cache_lookup_assert.svh"

module ltc_datapath import ltc_pkg::*; #(
	parameter int unsigned ENTRY_COUNT = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ltc_cmd_t               cmd,
	output ltc_status_t            status,
	input  logic [ID_W-1:0]        req_id,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_of_range,
	output logic                   hit,
	output logic [WAY_W-1:0]       way,
	output logic [CNT_W-1:0]       hit_count,
	output logic [CNT_W-1:0]       miss_count
);

	localparam int unsigned IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam logic [IDX_W-1:0] OLDEST_AGE = IDX_W'(ENTRY_COUNT - 1);

	// configuration
	logic             cache_enable_q;
	logic [ID_W-1:0]  stored_count_q;

	// entry state; age 0 is the most recently used valid entry
	logic [ENTRY_COUNT-1:0] valid_q;
	logic [ID_W-1:0]        tag_q [ENTRY_COUNT];
	logic [IDX_W-1:0]       age_q [ENTRY_COUNT];

	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [ID_W-1:0]  id_q;

	// lookup results
	logic                   oor_s1;
	logic                   found_s1;
	logic                   count_s1;
	logic [ENTRY_COUNT-1:0] sel_s1;
	logic [IDX_W-1:0]       way_s1;
	logic [IDX_W-1:0]       hit_age_s1;

	logic                   out_valid_q;
	logic                   oor_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       way_q;
	logic [CNT_W-1:0]       hit_count_q;
	logic [CNT_W-1:0]       miss_count_q;

	logic [ENTRY_COUNT-1:0] match;
	logic [ENTRY_COUNT-1:0] oldest;
	logic [ENTRY_COUNT-1:0] hit_oh;
	logic [ENTRY_COUNT-1:0] free_oh;
	logic [ENTRY_COUNT-1:0] oldest_oh;
	logic [ENTRY_COUNT-1:0] victim_oh;
	logic [ENTRY_COUNT-1:0] sel;
	logic                   found;
	logic                   oor;
	logic [IDX_W-1:0]       way_enc;
	logic [IDX_W-1:0]       hit_age;
	logic [CNT_W-1:0]       hits_next;
	logic [CNT_W-1:0]       misses_next;

	always_comb begin
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			match[i]  = valid_q[i] && (tag_q[i] == id_q);
			oldest[i] = (age_q[i] == OLDEST_AGE);
		end
		// isolate the lowest set bit
		hit_oh    = match & (~match + 1'b1);
		free_oh   = ~valid_q & (valid_q + 1'b1);
		oldest_oh = oldest & (~oldest + 1'b1);
		// unwritten entries go first, lowest index first
		victim_oh = (&valid_q) ? oldest_oh : free_oh;
		oor       = (id_q >= stored_count_q);
		found     = cache_enable_q && !oor && (|match);
		if (oor) begin
			sel = '0;
		end else if (found) begin
			sel = hit_oh;
		end else begin
			sel = victim_oh;
		end
		way_enc = '0;
		hit_age = '0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			if (sel[i]) begin
				way_enc = way_enc | IDX_W'(i);
				hit_age = hit_age | age_q[i];
			end
		end
	end

	always_comb begin
		hits_next   = hits_q;
		misses_next = misses_q;
		if (count_s1) begin
			if (found_s1) begin
				if (hits_q != '1) begin
					hits_next = hits_q + 1'b1;
				end
			end else if (misses_q != '1) begin
				misses_next = misses_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_enable_q <= 1'b1;
			stored_count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CACHE_ENABLE: cache_enable_q <= cfg_data[0];
				REG_STORED_COUNT: stored_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q <= req_id;
		end
		if (cmd.evaluate) begin
			oor_s1     <= oor;
			found_s1   <= found;
			count_s1   <= cache_enable_q && !oor;
			sel_s1     <= sel;
			way_s1     <= way_enc;
			hit_age_s1 <= hit_age;
		end
		if (cmd.commit) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				if (sel_s1[i]) begin
					age_q[i] <= '0;
					if (!found_s1) begin
						tag_q[i] <= id_q;
					end
				end else if (valid_q[i] && !oor_s1 && (!found_s1 || age_q[i] < hit_age_s1)) begin
					// age every entry more recent than the one being touched
					age_q[i] <= age_q[i] + 1'b1;
				end
			end
			oor_q        <= oor_s1;
			hit_q        <= found_s1;
			way_q        <= way_s1;
			hit_count_q  <= hits_next;
			miss_count_q <= misses_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (!found_s1) begin
					valid_q <= valid_q | sel_s1;
				end
				hits_q      <= hits_next;
				misses_q    <= misses_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_blocked = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_of_range = oor_q;
	assign hit          = hit_q;
	assign way          = WAY_W'(way_q);
	assign hit_count    = hit_count_q;
	assign miss_count   = miss_count_q;

	`LTC_ASSERT_IMP(a_one_entry_touched, clk, arst_n, cmd.commit && !oor_s1, $onehot(sel_s1))
	`LTC_ASSERT_IMP(a_refused_untouched, clk, arst_n, cmd.commit && oor_s1, sel_s1 == '0 && !found_s1)
	`LTC_ASSERT_NXT(a_touched_is_valid, clk, arst_n, cmd.commit, (valid_q & sel_s1) == sel_s1)

endmodule

// File: hdl/lru_tag_cache_lookup.sv
// Channel | Direction | Signals
// request | in        | in_valid, in_ready, req_id
// result  | out       | out_valid, out_ready, out_of_range, hit, way, hit_count, miss_count
// config  | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A request passes through accept, a parallel tag compare and victim pick over all
// ENTRY_COUNT entries, then the state update that loads the result register.
// The next request is accepted in the cycle after the update.
// A result not yet taken holds the update step of the request behind it.
// Reset clears valid bits, counters and stored count, enables cache; no clearing pass.
// Configuration writes are taken in every cycle.
module lru_tag_cache_lookup import ltc_pkg::*; #(
	parameter int unsigned ENTRY_COUNT = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [ID_W-1:0]        req_id,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_of_range,
	output logic                   hit,
	output logic [WAY_W-1:0]       way,
	output logic [CNT_W-1:0]       hit_count,
	output logic [CNT_W-1:0]       miss_count,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	ltc_cmd_t    cmd;
	ltc_status_t status;

	assign cfg_ready = 1'b1;

	ltc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ltc_datapath #(
		.ENTRY_COUNT (ENTRY_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_id       (req_id),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_of_range (out_of_range),
		.hit          (hit),
		.way          (way),
		.hit_count    (hit_count),
		.miss_count   (miss_count)
	);

endmodule
